// File: sv/rafdq_pkg.sv
package rafdq_pkg;

	// Queue and history sizing
	localparam int QUEUE_DEPTH    = 16;
	localparam int HISTORY_LENGTH = 32;

	localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
	localparam int HC_W     = $clog2(HISTORY_LENGTH + 2);
	localparam int ID_W     = 16;
	localparam int RATIO_W  = 17;
	localparam int MAXLEN_W = 4;
	localparam int LEN_W    = (CNT_W > MAXLEN_W) ? CNT_W : MAXLEN_W;
	localparam int PROD_W   = RATIO_W + HC_W;
	localparam int CFG_W    = RATIO_W;

	localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = MAXLEN_W'(12);

	// Register indexes
	localparam logic CFG_DROP_RATIO = 1'b0;
	localparam logic CFG_MAX_LEN    = 1'b1;

	// Command modes
	localparam logic [2:0] MODE_PUSH     = 3'd0;
	localparam logic [2:0] MODE_MARK_REF = 3'd1;
	localparam logic [2:0] MODE_MARK_REM = 3'd2;
	localparam logic [2:0] MODE_RELEASE  = 3'd3;
	localparam logic [2:0] MODE_FLUSH    = 3'd4;

	// Result status codes
	localparam logic [1:0] STAT_RELEASED = 2'd0;
	localparam logic [1:0] STAT_EOS      = 2'd1;
	localparam logic [1:0] STAT_REFUSED  = 2'd2;

	typedef struct packed {
		logic [2:0]      mode;
		logic [ID_W-1:0] frame_id;
	} cmd_t;

	typedef struct packed {
		logic [1:0]      status;
		logic [ID_W-1:0] frame_id_res;
		logic            dropped;
		logic            last;
	} res_t;

endpackage

// File: sv/reference_aware_frame_drop_queue_unit.sv
// Channel     | Signals                              | Handshake
// ------------+--------------------------------------+-----------------------------------
// command     | start, busy, item                    | taken when start && !busy
// result      | result_strobe, result                | one cycle per transaction, no stall
// config      | cfg_we, cfg_index, cfg_data          | written when cfg_we is high
//
// Push and unused modes leave the block idle; a refused push shows its result the next cycle.
// Marks walk the queue one slot a cycle through a single id comparator, from the head to the
// first match or the tail; a mark on an empty queue leaves the block idle.
// Release examines one head a cycle through the single drop-decision unit (17x6 multiply
// and compare). Flush emits each queued frame in turn, then an end-of-stream result.
// arst_n clears the queue pointers, counters and history; slot contents are not cleared.
// busy is high while a mark, release or flush is in progress.
module reference_aware_frame_drop_queue_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  rafdq_pkg::cmd_t                item,
	output logic                           result_strobe,
	output rafdq_pkg::res_t                result,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [rafdq_pkg::CFG_W-1:0]    cfg_data
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MARK  = 3'd1;
	localparam logic [2:0] ST_REL   = 3'd2;
	localparam logic [2:0] ST_FLUSH = 3'd3;

	localparam int D   = rafdq_pkg::QUEUE_DEPTH;
	localparam int H   = rafdq_pkg::HISTORY_LENGTH;
	localparam int PW  = rafdq_pkg::PTR_W;
	localparam int CW  = rafdq_pkg::CNT_W;
	localparam int HW  = rafdq_pkg::HC_W;
	localparam int IW  = rafdq_pkg::ID_W;
	localparam int LW  = rafdq_pkg::LEN_W;
	localparam int PRW = rafdq_pkg::PROD_W;
	localparam int SW  = CW + 1;

	// Slot storage
	logic [IW-1:0] ids_q   [D];
	logic          ref_q   [D];
	logic          inbuf_q [D];

	logic [2:0]                        state_q;
	logic [PW-1:0]                     head_q;
	logic [CW-1:0]                     count_q;
	logic [PW-1:0]                     walk_q;
	logic [CW-1:0]                     walk_cnt_q;
	logic [IW-1:0]                     op_id_q;
	logic                              op_ref_q;
	logic [H-1:0]                      hist_q;
	logic [HW-1:0]                     hist_cnt_q;
	logic [HW-1:0]                     dropped_q;
	logic [HW-1:0]                     total_q;
	logic [rafdq_pkg::RATIO_W-1:0]     ratio_q;
	logic [rafdq_pkg::MAXLEN_W-1:0]    max_len_q;
	rafdq_pkg::res_t                   pend_q;
	logic                              pend_v_q;
	rafdq_pkg::res_t                   result_q;
	logic                              strobe_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == PW'(D - 1)) ? '0 : p + PW'(1);
	endfunction

	// Tail slot for a push
	logic [SW-1:0] tail_sum;
	logic [PW-1:0] tail;
	assign tail_sum = SW'(head_q) + SW'(count_q);
	assign tail     = (tail_sum >= SW'(D)) ? PW'(tail_sum - SW'(D)) : PW'(tail_sum);

	logic accept;
	logic full;
	assign accept = start && !busy;
	assign full   = (count_q == CW'(D));

	// Head inspection and drop decision
	logic          over;
	logic          head_pop;
	logic [PRW-1:0] prod;
	logic [PRW-1:0] drop_lhs;
	logic          drop;
	logic          old_bit;
	assign over     = LW'(count_q) > LW'(max_len_q);
	assign head_pop = (count_q != '0) &&
		(!inbuf_q[head_q] || ref_q[head_q] || over);
	assign prod     = PRW'(ratio_q) * PRW'(total_q);
	assign drop_lhs = PRW'({dropped_q, 16'b0});
	assign drop     = !ref_q[head_q] && !over && (drop_lhs < prod);
	assign old_bit  = hist_q[H-1];

	// Mark walk compare
	logic mark_hit;
	logic mark_end;
	assign mark_hit = (ids_q[walk_q] == op_id_q);
	assign mark_end = (walk_cnt_q + CW'(1) >= count_q);

	// Result strobe for the coming cycle
	logic strobe_next;
	assign strobe_next =
		(state_q == ST_IDLE && accept && item.mode == rafdq_pkg::MODE_PUSH && full) ||
		(state_q == ST_REL && pend_v_q) ||
		(state_q == ST_FLUSH);

	// Slot writes
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && item.mode == rafdq_pkg::MODE_PUSH && !full) begin
			ids_q[tail]   <= item.frame_id;
			ref_q[tail]   <= 1'b0;
			inbuf_q[tail] <= 1'b1;
		end else if (state_q == ST_MARK && mark_hit) begin
			if (op_ref_q)
				ref_q[walk_q] <= 1'b1;
			else
				inbuf_q[walk_q] <= 1'b0;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q   <= '0;
			max_len_q <= rafdq_pkg::MAXLEN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rafdq_pkg::CFG_DROP_RATIO: ratio_q   <= cfg_data;
				rafdq_pkg::CFG_MAX_LEN:    max_len_q <= cfg_data[rafdq_pkg::MAXLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_q     <= '0;
			count_q    <= '0;
			walk_q     <= '0;
			walk_cnt_q <= '0;
			op_id_q    <= '0;
			op_ref_q   <= 1'b0;
			hist_q     <= '0;
			hist_cnt_q <= '0;
			dropped_q  <= '0;
			total_q    <= HW'(1);
			pend_q     <= '0;
			pend_v_q   <= 1'b0;
			result_q   <= '0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= strobe_next;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (item.mode)
							rafdq_pkg::MODE_PUSH: begin
								if (full) begin
									result_q <= {rafdq_pkg::STAT_REFUSED, item.frame_id,
										1'b0, 1'b1};
								end else begin
									count_q <= count_q + CW'(1);
								end
							end
							rafdq_pkg::MODE_MARK_REF, rafdq_pkg::MODE_MARK_REM: begin
								if (count_q != '0) begin
									state_q    <= ST_MARK;
									walk_q     <= head_q;
									walk_cnt_q <= '0;
									op_id_q    <= item.frame_id;
									op_ref_q   <= (item.mode == rafdq_pkg::MODE_MARK_REF);
								end
							end
							rafdq_pkg::MODE_RELEASE: state_q <= ST_REL;
							rafdq_pkg::MODE_FLUSH:   state_q <= ST_FLUSH;
							default: ;
						endcase
					end
				end
				ST_MARK: begin
					walk_q     <= ptr_inc(walk_q);
					walk_cnt_q <= walk_cnt_q + CW'(1);
					if (mark_hit || mark_end)
						state_q <= ST_IDLE;
				end
				ST_REL: begin
					if (head_pop) begin
						// emit the previous pop, hold this one until the next head is known
						if (pend_v_q)
							result_q <= pend_q;
						pend_q   <= {rafdq_pkg::STAT_RELEASED, ids_q[head_q], drop, 1'b0};
						pend_v_q <= 1'b1;
						head_q   <= ptr_inc(head_q);
						count_q  <= count_q - CW'(1);
						// sliding window update
						hist_q <= (hist_q << 1) | H'(drop);
						if (hist_cnt_q == HW'(H)) begin
							dropped_q <= dropped_q + HW'(drop) - HW'(old_bit);
						end else begin
							dropped_q  <= dropped_q + HW'(drop);
							total_q    <= total_q + HW'(1);
							hist_cnt_q <= hist_cnt_q + HW'(1);
						end
					end else begin
						if (pend_v_q)
							result_q <= {pend_q.status, pend_q.frame_id_res,
								pend_q.dropped, 1'b1};
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				ST_FLUSH: begin
					if (count_q != '0) begin
						result_q <= {rafdq_pkg::STAT_RELEASED, ids_q[head_q], 1'b0, 1'b0};
						head_q   <= ptr_inc(head_q);
						count_q  <= count_q - CW'(1);
					end else begin
						result_q <= {rafdq_pkg::STAT_EOS, {IW{1'b0}}, 1'b0, 1'b1};
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign result_strobe = strobe_q;
	assign result        = result_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(D))
		else $error("queue count beyond depth");

	a_total_track: assert property (@(posedge clk) disable iff (!arst_n)
		total_q == hist_cnt_q + HW'(1))
		else $error("total count out of step with history count");

	a_dropped_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dropped_q <= hist_cnt_q)
		else $error("dropped count exceeds window");

	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_v_q)
		else $error("pending release left behind");

	a_rel_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REL && !head_pop && pend_v_q) |=> (result_strobe && result.last))
		else $error("release ended without a final transaction");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int SETTLE_CYCLES = rafdq_pkg::QUEUE_DEPTH + 4;
	localparam int DRAIN_LIMIT   = 4000;
	localparam int MAX_GAP       = 20;
	localparam int QD            = rafdq_pkg::QUEUE_DEPTH;
	localparam int HL            = rafdq_pkg::HISTORY_LENGTH;
	localparam int IDW           = rafdq_pkg::ID_W;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	rafdq_pkg::cmd_t              item;
	logic                         result_strobe;
	rafdq_pkg::res_t              result;
	logic                         cfg_we;
	logic                         cfg_index;
	logic [rafdq_pkg::CFG_W-1:0]  cfg_data;

	reference_aware_frame_drop_queue_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.item          (item),
		.result_strobe (result_strobe),
		.result        (result),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Shadow of the frame queue and drop window
	logic [IDW-1:0]                   slot_id     [QD];
	bit                               slot_ref    [QD];
	bit                               slot_in_buf [QD];
	int unsigned                      q_head;
	int unsigned                      q_count;
	logic [HL:0]                      drop_hist;
	int unsigned                      hist_len;
	int unsigned                      drops_in_window;
	int unsigned                      decisions_in_window;
	logic [rafdq_pkg::RATIO_W-1:0]    cur_ratio;
	logic [rafdq_pkg::MAXLEN_W-1:0]   cur_max_len;

	// Releases still owed by the block, oldest first
	rafdq_pkg::res_t         pending_releases[$];
	int                      errors;
	int                      sender_idle_pct;
	logic [IDW-1:0]          next_id;

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Drop decision over the sliding window; updates the counts
	function automatic bit drop_verdict(input bit referenced, input bit over);
		bit drop;
		drop = !referenced && !over &&
			(longint'(drops_in_window) * 65536 < longint'(cur_ratio) * decisions_in_window);
		if (drop)
			drops_in_window++;
		decisions_in_window++;
		drop_hist = {drop_hist[HL-1:0], drop};
		hist_len++;
		if (hist_len > HL) begin
			if (drop_hist[HL])
				drops_in_window--;
			drop_hist[HL] = 1'b0;
			decisions_in_window--;
			hist_len--;
		end
		return drop;
	endfunction

	// Marks only the matching entry nearest the head
	function automatic void mark_frame(input logic [IDW-1:0] id, input bit as_ref);
		int unsigned s;
		for (int unsigned i = 0; i < q_count; i++) begin
			s = (q_head + i) % QD;
			if (slot_id[s] == id) begin
				if (as_ref)
					slot_ref[s] = 1'b1;
				else
					slot_in_buf[s] = 1'b0;
				return;
			end
		end
	endfunction

	// Applies one command to the shadow queue and queues the releases it owes
	function automatic void advance_queue(input rafdq_pkg::cmd_t c);
		rafdq_pkg::res_t batch[$];
		rafdq_pkg::res_t r;
		int unsigned     s;
		bit              over;
		bit              drop;
		r = '0;
		case (c.mode)
			rafdq_pkg::MODE_PUSH: begin
				if (q_count >= QD) begin
					r.status = rafdq_pkg::STAT_REFUSED;
					r.frame_id_res = c.frame_id;
					batch.insert(batch.size(), r);
				end else begin
					s = (q_head + q_count) % QD;
					slot_id[s] = c.frame_id;
					slot_ref[s] = 1'b0;
					slot_in_buf[s] = 1'b1;
					q_count++;
				end
			end
			rafdq_pkg::MODE_MARK_REF: mark_frame(c.frame_id, 1'b1);
			rafdq_pkg::MODE_MARK_REM: mark_frame(c.frame_id, 1'b0);
			rafdq_pkg::MODE_RELEASE: begin
				while (q_count > 0) begin
					s = q_head;
					over = q_count > cur_max_len;
					if (slot_in_buf[s] && !slot_ref[s] && !over)
						break;
					drop = drop_verdict(slot_ref[s], over);
					r.status = rafdq_pkg::STAT_RELEASED;
					r.frame_id_res = slot_id[s];
					r.dropped = drop;
					batch.insert(batch.size(), r);
					q_head = (q_head + 1) % QD;
					q_count--;
				end
			end
			rafdq_pkg::MODE_FLUSH: begin
				while (q_count > 0) begin
					r.status = rafdq_pkg::STAT_RELEASED;
					r.frame_id_res = slot_id[q_head];
					r.dropped = 1'b0;
					batch.insert(batch.size(), r);
					q_head = (q_head + 1) % QD;
					q_count--;
				end
				r.status = rafdq_pkg::STAT_EOS;
				r.frame_id_res = '0;
				r.dropped = 1'b0;
				batch.insert(batch.size(), r);
			end
			default: ;
		endcase
		if (batch.size() > 0)
			batch[batch.size()-1].last = 1'b1;
		pending_releases = {pending_releases, batch};
	endfunction

	// Some id currently queued, else a random one
	function automatic logic [IDW-1:0] queued_id(input bit at_head);
		if (q_count == 0)
			return IDW'($urandom);
		if (at_head)
			return slot_id[q_head];
		return slot_id[(q_head + $urandom_range(q_count - 1)) % QD];
	endfunction

	// Result checker: every strobe must match the oldest owed release
	always @(posedge clk) begin : release_check
		rafdq_pkg::res_t want;
		if (arst_n && result_strobe) begin
			if (pending_releases.size() == 0) begin
				$error("unexpected result: status %0d frame_id_res %h dropped %0d last %0d",
					result.status, result.frame_id_res, result.dropped, result.last);
				errors++;
			end else begin
				want = pending_releases[0];
				pending_releases.delete(0);
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					errors++;
				end
				if (result.frame_id_res !== want.frame_id_res) begin
					$error("frame_id_res: expected %h, got %h",
						want.frame_id_res, result.frame_id_res);
					errors++;
				end
				if (result.dropped !== want.dropped) begin
					$error("dropped: expected %0d, got %0d", want.dropped, result.dropped);
					errors++;
				end
				if (result.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, result.last);
					errors++;
				end
			end
		end
	end

	// One command transaction, with random idling in front of it
	task automatic send_cmd(input logic [2:0] mode, input logic [IDW-1:0] id);
		int              gap;
		rafdq_pkg::cmd_t c;
		gap = 0;
		while ($urandom_range(99) < sender_idle_pct && gap < MAX_GAP)
			gap++;
		c.mode = mode;
		c.frame_id = id;
		@(negedge clk);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item = c;
		start = 1'b1;
		while (busy)
			@(negedge clk);
		@(posedge clk);
		advance_queue(c);
	endtask

	// Hold off until all owed releases are in and the block has gone quiet
	task automatic settle();
		int waited;
		@(negedge clk);
		start = 1'b0;
		waited = 0;
		while ((pending_releases.size() != 0 || busy) && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (pending_releases.size() != 0) begin
			$error("%0d releases never arrived", pending_releases.size());
			errors++;
			pending_releases.delete();
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_config(input logic [rafdq_pkg::RATIO_W-1:0] ratio,
			input logic [rafdq_pkg::MAXLEN_W-1:0] max_len);
		settle();
		cfg_we = 1'b1;
		cfg_index = rafdq_pkg::CFG_DROP_RATIO;
		cfg_data = rafdq_pkg::CFG_W'(ratio);
		@(negedge clk);
		cfg_index = rafdq_pkg::CFG_MAX_LEN;
		cfg_data = rafdq_pkg::CFG_W'(max_len);
		@(negedge clk);
		cfg_we = 1'b0;
		cur_ratio = ratio;
		cur_max_len = max_len;
	endtask

	// Push, duplicate ids, marks with and without a match, partial releases, flushes
	task automatic test_marks_and_release();
		sender_idle_pct = 0;
		send_cmd(rafdq_pkg::MODE_PUSH, 16'h0000);
		send_cmd(rafdq_pkg::MODE_PUSH, 16'hFFFF);
		send_cmd(rafdq_pkg::MODE_PUSH, 16'h1234);
		send_cmd(rafdq_pkg::MODE_PUSH, 16'h1234);
		send_cmd(rafdq_pkg::MODE_MARK_REF, 16'h1234);
		send_cmd(rafdq_pkg::MODE_MARK_REF, 16'hBEEF);
		send_cmd(rafdq_pkg::MODE_MARK_REM, 16'h0000);
		send_cmd(rafdq_pkg::MODE_RELEASE, 16'h0000);
		send_cmd(rafdq_pkg::MODE_MARK_REM, 16'hFFFF);
		send_cmd(rafdq_pkg::MODE_RELEASE, 16'hFFFF);
		send_cmd(rafdq_pkg::MODE_RELEASE, 16'h5555);
		send_cmd(3'd5, 16'hAAAA);
		send_cmd(3'd7, 16'h5555);
		send_cmd(rafdq_pkg::MODE_FLUSH, 16'h0000);
		send_cmd(rafdq_pkg::MODE_FLUSH, 16'hFFFF);
	endtask

	// Fill to depth, one refused push, forced release over length, flush
	task automatic test_full_queue();
		sender_idle_pct = 0;
		for (int k = 0; k < QD; k++)
			send_cmd(rafdq_pkg::MODE_PUSH, IDW'($urandom));
		send_cmd(rafdq_pkg::MODE_PUSH, 16'hFFFF);
		send_cmd(rafdq_pkg::MODE_RELEASE, 16'h0000);
		send_cmd(rafdq_pkg::MODE_FLUSH, 16'h0000);
	endtask

	// Mostly frame groups (pushes, marks, release), some noise transactions
	task automatic test_random_traffic(input int n_items, input int idle_pct);
		int         sent;
		int         burst;
		int         n_marks;
		logic [2:0] m;
		sender_idle_pct = idle_pct;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 20) begin
				m = 3'($urandom_range(7));
				send_cmd(m, $urandom_range(1) ? queued_id(1'b0) : IDW'($urandom));
				if (m <= rafdq_pkg::MODE_FLUSH)
					sent++;
			end else begin
				if ($urandom_range(3) == 0)
					next_id = IDW'($urandom);
				burst = ($urandom_range(99) < 15) ? $urandom_range(8, 17) : $urandom_range(1, 4);
				for (int k = 0; k < burst; k++) begin
					if ($urandom_range(9) == 0) begin
						send_cmd(rafdq_pkg::MODE_PUSH, queued_id(1'b0));
					end else begin
						send_cmd(rafdq_pkg::MODE_PUSH, next_id);
						next_id++;
					end
					sent++;
				end
				n_marks = $urandom_range(3);
				for (int k = 0; k < n_marks; k++) begin
					send_cmd(rafdq_pkg::MODE_MARK_REF, queued_id(1'b0));
					sent++;
				end
				n_marks = $urandom_range(3);
				for (int k = 0; k < n_marks; k++) begin
					send_cmd(rafdq_pkg::MODE_MARK_REM, queued_id($urandom_range(99) < 60));
					sent++;
				end
				send_cmd(rafdq_pkg::MODE_RELEASE, IDW'($urandom));
				sent++;
				if ($urandom_range(99) < 5) begin
					send_cmd(rafdq_pkg::MODE_FLUSH, IDW'($urandom));
					sent++;
				end
			end
		end
	endtask

	// Sequencer
	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = rafdq_pkg::CFG_DROP_RATIO;
		cfg_data = '0;
		errors = 0;
		sender_idle_pct = 0;
		next_id = IDW'($urandom);
		q_head = 0;
		q_count = 0;
		drop_hist = '0;
		hist_len = 0;
		drops_in_window = 0;
		decisions_in_window = 1;
		cur_ratio = '0;
		cur_max_len = rafdq_pkg::MAXLEN_RESET;
		for (int i = 0; i < QD; i++) begin
			slot_id[i] = '0;
			slot_ref[i] = 1'b0;
			slot_in_buf[i] = 1'b0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_marks_and_release();
		test_full_queue();

		// Sender idles lightly
		write_config(17'd65536, 4'd15);
		test_random_traffic(30, 7);
		write_config(17'd21845, 4'd4);
		test_random_traffic(15, 7);

		// Sender idles heavily; zero max length forces every frame out
		write_config(17'd40000, 4'd0);
		test_random_traffic(15, 47);
		write_config(17'($urandom_range(65536)), 4'($urandom_range(1, 15)));
		test_random_traffic(30, 47);

		// No idling
		write_config(17'd1, 4'd1);
		test_random_traffic(15, 0);
		settle();
		test_random_traffic(10, 0);
		write_config(17'd0, 4'd12);
		test_random_traffic(10, 0);
		write_config(17'd65535, 4'd12);
		test_random_traffic(15, 0);

		settle();
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: filelist.f
sv/rafdq_pkg.sv
sv/reference_aware_frame_drop_queue_unit.sv
tb/sv/testbench.sv
